>>> hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds command codes, character codes, the decoded command word and default geometry.
// No dependencies.
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 8;

	localparam int CELL_W = 16;

	// Operation codes on the input channel.
	localparam logic [1:0] OP_WRITE      = 2'd0;
	localparam logic [1:0] OP_SET_CURSOR = 2'd1;
	localparam logic [1:0] OP_CLEAR      = 2'd2;
	localparam logic [1:0] OP_READ       = 2'd3;

	// Character codes with special meaning.
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Cell contents after reset: a space with attribute zero.
	localparam logic [CELL_W-1:0] RESET_CELL = {8'h00, CH_SPACE};

	typedef enum logic [3:0] {
		K_NOP,
		K_PUT,
		K_BS,
		K_TAB,
		K_CR,
		K_LF,
		K_SETC,
		K_CLEAR,
		K_READ
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  chr;
		logic        col_ok;
		logic [7:0]  col;
		logic        row_ok;
		logic [7:0]  row;
		logic        idx_ok;
		logic [10:0] idx;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

endpackage

`default_nettype wire

>>> hw/rtl/text_console_writer.sv
// Top level of the text console writer: front end, back end and screen RAM.
// Depends on tcw_pkg, tcw_front, tcw_back and tcw_ram.
//
// Usage: one command word enters on the input channel (in_valid/in_ready) and
// gives exactly one result word on the output channel (out_valid/out_ready).
// Commands: write character, set cursor, clear screen, read cell. The result
// carries the cursor after the command and, for a read, the cell contents.
// The user writes the colour attribute through cfg_wr_en/cfg_wr_data only
// while idle; the block itself does not enforce this.
//
// A decoded command waits in a two-entry queue; the sequencer takes one when
// the result register is empty. A write, set cursor or out-of-range read
// returns in the cycle after it leaves the queue; a read passes first through
// the registered read port of the screen RAM and the S_READ state. The
// sequencer takes no new word while the single result register holds one.
// A write that scrolls walks the RAM once through its one read and one write
// port, then blanks the last row; a clear blanks every cell.
//
// Reset: cursor and colour go to zero and the RAM is swept to blank cells
// with in_ready held low. A stalled receiver holds the result; the queue
// keeps taking up to two words.
`default_nettype none

module text_console_writer #(
	parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tcw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  char_code,
	input  wire logic [7:0]  new_column,
	input  wire logic [7:0]  new_row,
	input  wire logic [10:0] cell_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [6:0]       cursor_column,
	output logic [4:0]       cursor_row,
	output logic [10:0]      cursor_location,
	output logic [15:0]      cell_word
);

	import tcw_pkg::*;

	localparam int CellCnt = COLUMNS * ROWS;
	localparam int AddrW   = $clog2(CellCnt);

	queue_head_t       head;
	logic              pop;
	logic              run;
	logic              ram_we;
	logic [AddrW-1:0]  ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AddrW-1:0]  ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// Decode and queue incoming command words.
	tcw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.run        (run),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.char_code  (char_code),
		.new_column (new_column),
		.new_row    (new_row),
		.cell_index (cell_index),
		.head       (head),
		.pop        (pop)
	);

	// Execute commands against the cursor and the screen store.
	tcw_back #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.pop             (pop),
		.run             (run),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_re          (ram_re),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cursor_column   (cursor_column),
		.cursor_row      (cursor_row),
		.cursor_location (cursor_location),
		.cell_word       (cell_word)
	);

	// Screen cells: attribute in the high byte, character in the low byte.
	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CellCnt)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

>>> hw/rtl/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the screen cell store. No dependencies.
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tcw_front.sv
// Front end of the text console writer: accepts command words, decodes them
// and holds them in a two-entry queue for the back end. Depends on tcw_pkg.
`default_nettype none

module tcw_front #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               run,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         operation,
	input  wire logic [7:0]         char_code,
	input  wire logic [7:0]         new_column,
	input  wire logic [7:0]         new_row,
	input  wire logic [10:0]        cell_index,
	output tcw_pkg::queue_head_t    head,
	input  wire logic               pop
);

	import tcw_pkg::*;

	localparam logic [1:0] QFull = 2'd2;

	cmd_t       cmd_in;
	cmd_t       entry_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push;

	// Decode the operation and the character class up front so the back end
	// only has to act on a kind.
	always_comb begin
		cmd_in.chr    = char_code;
		cmd_in.col    = new_column;
		cmd_in.row    = new_row;
		cmd_in.idx    = cell_index;
		cmd_in.col_ok = int'(new_column) < COLUMNS;
		cmd_in.row_ok = int'(new_row) < ROWS;
		cmd_in.idx_ok = int'(cell_index) < COLUMNS * ROWS;
		case (operation)
			OP_WRITE: begin
				if (char_code == CH_BS) begin
					cmd_in.kind = K_BS;
				end else if (char_code == CH_TAB) begin
					cmd_in.kind = K_TAB;
				end else if (char_code == CH_CR) begin
					cmd_in.kind = K_CR;
				end else if (char_code == CH_LF) begin
					cmd_in.kind = K_LF;
				end else if (char_code >= CH_SPACE) begin
					cmd_in.kind = K_PUT;
				end else begin
					cmd_in.kind = K_NOP;
				end
			end
			OP_SET_CURSOR: cmd_in.kind = K_SETC;
			OP_CLEAR:      cmd_in.kind = K_CLEAR;
			OP_READ:       cmd_in.kind = K_READ;
			default:       cmd_in.kind = K_NOP;
		endcase
	end

	assign in_ready   = run && (count_q != QFull);
	assign push       = in_valid && in_ready;
	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tcw_back.sv
// Back end of the text console writer: cursor, colour register, command
// sequencer for the screen store and the result register. Depends on tcw_pkg.
`default_nettype none

module tcw_back #(
	parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tcw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF,
	localparam int CellCnt = COLUMNS * ROWS,
	localparam int AddrW   = $clog2(CellCnt)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tcw_pkg::queue_head_t      head,
	output logic                           pop,
	output logic                           run,
	input  wire logic                      cfg_wr_en,
	input  wire logic [7:0]                cfg_wr_data,
	output logic                           ram_we,
	output logic [AddrW-1:0]               ram_waddr,
	output logic [tcw_pkg::CELL_W-1:0]     ram_wdata,
	output logic                           ram_re,
	output logic [AddrW-1:0]               ram_raddr,
	input  wire logic [tcw_pkg::CELL_W-1:0] ram_rdata,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [6:0]                     cursor_column,
	output logic [4:0]                     cursor_row,
	output logic [10:0]                    cursor_location,
	output logic [15:0]                    cell_word
);

	import tcw_pkg::*;

	localparam int ColW = $clog2(COLUMNS);
	localparam int RowW = $clog2(ROWS + 1);
	localparam int NcW  = $clog2(COLUMNS + TAB_STOP);
	localparam int CntW = $clog2(CellCnt + 1);

	localparam logic [CntW-1:0] LastCell   = CntW'(CellCnt - 1);
	localparam logic [CntW-1:0] LastCopied = CntW'(CellCnt - COLUMNS - 1);

	typedef enum logic [4:0] {
		S_INIT   = 5'b00001,
		S_IDLE   = 5'b00010,
		S_READ   = 5'b00100,
		S_SCROLL = 5'b01000,
		S_FILL   = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [ColW-1:0]   col_q, col_d;
	logic [RowW-1:0]   row_q, row_d;
	logic [CntW-1:0]   src_q, src_d;
	logic [CntW-1:0]   dst_q, dst_d;
	logic              vld_q, vld_d;
	logic [7:0]        colour_q;
	logic              load;
	logic [15:0]       word_d;
	logic [NcW-1:0]    ncol;
	logic [RowW-1:0]   nrow;
	logic              scroll;
	logic [AddrW-1:0]  loc_cur;
	logic [AddrW-1:0]  loc_out;
	logic [CELL_W-1:0] blank;

	logic              out_valid_q;
	logic [ColW-1:0]   out_col_q;
	logic [RowW-1:0]   out_row_q;
	logic [15:0]       out_word_q;

	// Next tab stop for every column, worked out at elaboration.
	logic [NcW-1:0] tab_next [COLUMNS];
	for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
		assign tab_next[g] = NcW'(g + TAB_STOP - (g % TAB_STOP));
	end

	assign blank   = {colour_q, CH_SPACE};
	assign loc_cur = AddrW'(row_q) * AddrW'(COLUMNS) + AddrW'(col_q);
	assign run     = (state_q != S_INIT);

	// Cursor motion of a write command, including the wrap at the right edge.
	always_comb begin
		ncol = NcW'(col_q);
		nrow = row_q;
		case (head.cmd.kind)
			K_PUT: ncol = NcW'(col_q) + NcW'(1);
			K_BS: begin
				if (col_q != '0) begin
					ncol = NcW'(col_q) - NcW'(1);
				end
			end
			K_TAB: ncol = tab_next[col_q];
			K_CR:  ncol = '0;
			K_LF: begin
				ncol = '0;
				nrow = row_q + RowW'(1);
			end
			default: ncol = NcW'(col_q);
		endcase
		if (ncol >= NcW'(COLUMNS)) begin
			ncol = '0;
			nrow = row_q + RowW'(1);
		end
		scroll = (nrow >= RowW'(ROWS));
	end

	always_comb begin
		state_d   = state_q;
		col_d     = col_q;
		row_d     = row_q;
		src_d     = src_q;
		dst_d     = dst_q;
		vld_d     = 1'b0;
		pop       = 1'b0;
		load      = 1'b0;
		word_d    = '0;
		ram_we    = 1'b0;
		ram_waddr = dst_q[AddrW-1:0];
		ram_wdata = blank;
		ram_re    = 1'b0;
		ram_raddr = src_q[AddrW-1:0];
		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = RESET_CELL;
				dst_d     = dst_q + CntW'(1);
				if (dst_q == LastCell) begin
					dst_d   = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (head.valid && !out_valid_q) begin
					pop = 1'b1;
					case (head.cmd.kind)
						K_SETC: begin
							if (head.cmd.col_ok) begin
								col_d = ColW'(head.cmd.col);
							end
							if (head.cmd.row_ok) begin
								row_d = RowW'(head.cmd.row);
							end
							load = 1'b1;
						end
						K_CLEAR: begin
							col_d   = '0;
							row_d   = '0;
							dst_d   = '0;
							state_d = S_FILL;
						end
						K_READ: begin
							if (head.cmd.idx_ok) begin
								ram_re    = 1'b1;
								ram_raddr = AddrW'(head.cmd.idx);
								state_d   = S_READ;
							end else begin
								load = 1'b1;
							end
						end
						default: begin
							if (head.cmd.kind == K_PUT) begin
								ram_we    = 1'b1;
								ram_waddr = loc_cur;
								ram_wdata = {colour_q, head.cmd.chr};
							end
							col_d = ColW'(ncol);
							if (scroll) begin
								row_d   = RowW'(ROWS - 1);
								src_d   = CntW'(COLUMNS);
								dst_d   = '0;
								state_d = S_SCROLL;
							end else begin
								row_d = nrow;
								load  = 1'b1;
							end
						end
					endcase
				end
			end
			S_READ: begin
				load    = 1'b1;
				word_d  = ram_rdata;
				state_d = S_IDLE;
			end
			S_SCROLL: begin
				// Read one row ahead, write the word read in the cycle before.
				if (src_q < CntW'(CellCnt)) begin
					ram_re = 1'b1;
					src_d  = src_q + CntW'(1);
					vld_d  = 1'b1;
				end
				if (vld_q) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					dst_d     = dst_q + CntW'(1);
					if (dst_q == LastCopied) begin
						state_d = S_FILL;
					end
				end
			end
			S_FILL: begin
				ram_we = 1'b1;
				dst_d  = dst_q + CntW'(1);
				if (dst_q == LastCell) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			col_q       <= '0;
			row_q       <= '0;
			src_q       <= '0;
			dst_q       <= '0;
			vld_q       <= 1'b0;
			colour_q    <= 8'h00;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			src_q   <= src_d;
			dst_q   <= dst_d;
			vld_q   <= vld_d;
			if (cfg_wr_en) begin
				colour_q <= cfg_wr_data;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_col_q  <= col_d;
			out_row_q  <= row_d;
			out_word_q <= word_d;
		end
	end

	assign loc_out         = AddrW'(out_row_q) * AddrW'(COLUMNS) + AddrW'(out_col_q);
	assign out_valid       = out_valid_q;
	assign cursor_column   = 7'(out_col_q);
	assign cursor_row      = 5'(out_row_q);
	assign cursor_location = 11'(loc_out);
	assign cell_word       = out_word_q;

endmodule

`default_nettype wire

>>> hw/rtl/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg for default geometry.
`default_nettype none

module tcw_checker #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [6:0]  cursor_column,
	input wire logic [4:0]  cursor_row,
	input wire logic [10:0] cursor_location,
	input wire logic [15:0] cell_word
);

	// A stalled result word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(cursor_column) && $stable(cursor_row)
			&& $stable(cursor_location) && $stable(cell_word))
		else $error("result payload changed while stalled");

	// An offered result's cursor lies on the screen (row checked if ROWS <= 32).
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(cursor_column) < COLUMNS)
			&& (ROWS > 32 || int'(cursor_row) < ROWS))
		else $error("cursor off screen");

	// The location word agrees with the cursor coordinates.
	a_location: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (ROWS <= 32) |->
			cursor_location == 11'(int'(cursor_row) * COLUMNS + int'(cursor_column)))
		else $error("cursor location mismatch");

	// Coming out of reset the screen is being swept, so nothing is taken or given.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready && !out_valid)
		else $error("activity right after reset");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (.*);

`default_nettype wire
